// ----- rtl/core/morse_code_keyer_assert.svh -----
// Assertion macros for the checker file of the Morse keyer.
// Depends on nothing; expects signals clk and rst_n in the using scope.
`ifndef MORSE_CODE_KEYER_ASSERT_SVH
`define MORSE_CODE_KEYER_ASSERT_SVH

// Checked only outside reset.
`define MCK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mck check failed");

// Checked at every edge, reset included.
`define MCK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mck check failed");

`endif

// ----- rtl/core/mck_pkg.sv -----
// Shared types, constants and the Morse lookup for the keyer.
// Depends on nothing; used by every module of the keyer.
`default_nettype none

package mck_pkg;

  localparam int DOT_W  = 12;
  localparam int FACT_W = 4;
  localparam int DUR_W  = 16;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_DOT_MS      = 2'd0;
  localparam logic [IDX_W-1:0] REG_DASH_FACTOR = 2'd1;
  localparam logic [IDX_W-1:0] REG_WORD_FACTOR = 2'd2;

  localparam logic [DOT_W-1:0]  DOT_MS_RST      = 12'd250;
  localparam logic [FACT_W-1:0] DASH_FACTOR_RST = 4'd5;
  localparam logic [FACT_W-1:0] WORD_FACTOR_RST = 4'd7;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
  localparam logic [5:0]        DIGIT_BASE  = 6'd26;

  typedef struct packed {
    logic [DOT_W-1:0]  dot_ms;
    logic [FACT_W-1:0] dash_factor;
    logic [FACT_W-1:0] word_factor;
  } cfg_t;

  // One classified character: a word gap, or up to five symbols.
  // Bit i of dashes is 1 when symbol i is a dash.
  typedef struct packed {
    logic       is_space;
    logic [2:0] len;
    logic [4:0] dashes;
  } desc_t;

  typedef struct packed {
    logic [2:0] len;
    logic [4:0] dashes;
  } code_t;

  // Morse table: A-Z at 0..25, 0-9 at 26..35.
  function automatic code_t mck_lookup(input logic [5:0] entry);
    code_t c;
    case (entry)
      6'd0:  c = '{3'd2, 5'b00010};
      6'd1:  c = '{3'd4, 5'b00001};
      6'd2:  c = '{3'd4, 5'b00101};
      6'd3:  c = '{3'd3, 5'b00001};
      6'd4:  c = '{3'd1, 5'b00000};
      6'd5:  c = '{3'd4, 5'b00100};
      6'd6:  c = '{3'd3, 5'b00011};
      6'd7:  c = '{3'd4, 5'b00000};
      6'd8:  c = '{3'd2, 5'b00000};
      6'd9:  c = '{3'd4, 5'b01110};
      6'd10: c = '{3'd3, 5'b00101};
      6'd11: c = '{3'd4, 5'b00010};
      6'd12: c = '{3'd2, 5'b00011};
      6'd13: c = '{3'd2, 5'b00001};
      6'd14: c = '{3'd3, 5'b00111};
      6'd15: c = '{3'd4, 5'b00110};
      6'd16: c = '{3'd4, 5'b01011};
      6'd17: c = '{3'd3, 5'b00010};
      6'd18: c = '{3'd3, 5'b00000};
      6'd19: c = '{3'd1, 5'b00001};
      6'd20: c = '{3'd3, 5'b00100};
      6'd21: c = '{3'd4, 5'b01000};
      6'd22: c = '{3'd3, 5'b00110};
      6'd23: c = '{3'd4, 5'b01001};
      6'd24: c = '{3'd4, 5'b01101};
      6'd25: c = '{3'd4, 5'b00011};
      6'd26: c = '{3'd5, 5'b11111};
      6'd27: c = '{3'd5, 5'b11110};
      6'd28: c = '{3'd5, 5'b11100};
      6'd29: c = '{3'd5, 5'b11000};
      6'd30: c = '{3'd5, 5'b10000};
      6'd31: c = '{3'd5, 5'b00000};
      6'd32: c = '{3'd5, 5'b00001};
      6'd33: c = '{3'd5, 5'b00011};
      6'd34: c = '{3'd5, 5'b00111};
      6'd35: c = '{3'd5, 5'b01111};
      default: c = '{3'd1, 5'b00000};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mck_front.sv -----
// Front end of the keyer: folds case, classifies the character and
// looks up its Morse pattern. Depends on mck_pkg.
`default_nettype none

module mck_front
  import mck_pkg::*;
(
  input  wire logic              push,
  input  wire logic [CHAR_W-1:0] in_char_code,
  output logic                   full,
  input  wire logic              q_full,
  output logic                   q_wr_en,
  output desc_t                  q_wr_desc
);

  logic [CHAR_W-1:0] up_char;
  logic              is_letter;
  logic              is_digit;
  logic              is_space;
  logic [5:0]        entry;
  code_t             code;

  always_comb begin
    up_char = in_char_code;
    if (in_char_code inside {[CHAR_LO_A:CHAR_LO_Z]}) begin
      up_char = in_char_code - CASE_OFFSET;
    end
    is_space  = (in_char_code == CHAR_SPACE);
    is_letter = up_char inside {[CHAR_UP_A:CHAR_UP_Z]};
    is_digit  = up_char inside {[CHAR_ZERO:CHAR_NINE]};
    if (is_digit) begin
      entry = DIGIT_BASE + 6'(up_char - CHAR_ZERO);
    end else begin
      entry = 6'(up_char - CHAR_UP_A);
    end
    code = mck_lookup(entry);
  end

  assign full = q_full;

  // Drop anything that is neither a space, a letter nor a digit.
  assign q_wr_en   = push && !q_full && (is_space || is_letter || is_digit);
  assign q_wr_desc = '{is_space: is_space, len: code.len, dashes: code.dashes};

endmodule

`default_nettype wire

// ----- rtl/core/mck_fifo.sv -----
// Short descriptor queue between the keyer's front and back ends.
// Depends on mck_pkg for the descriptor type.
`default_nettype none

module mck_fifo
  import mck_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_en,
  input  wire desc_t wr_desc,
  output logic       q_full,
  input  wire logic  rd_en,
  output desc_t      rd_desc,
  output logic       q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t           mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_wr, do_rd;

  assign q_full  = (count_r == CW'(DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_desc = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mck_back.sv -----
// Back end of the keyer: walks one descriptor into the output register, one LED
// segment a cycle unless the receiver stalls. Depends on mck_pkg.
`default_nettype none

module mck_back
  import mck_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             q_empty,
  input  wire desc_t            rd_desc,
  output logic                  rd_en,
  input  wire logic             pop,
  output logic                  empty,
  output logic                  out_led_on,
  output logic [DUR_W-1:0]      out_duration_ms,
  output logic                  out_last
);

  desc_t             desc_r, desc_nxt;
  logic              busy_r, busy_nxt;
  logic [3:0]        step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              led_r, led_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic              last_r, last_nxt;

  logic [2:0]        sym;
  logic              seg_on;
  logic              seg_final;
  logic              sym_dash;
  logic              adv;
  logic              emit;
  logic              load;
  logic [DUR_W-1:0]  dot_dur, dash_dur, word_dur;

  always_comb begin
    dot_dur  = DUR_W'(cfg.dot_ms);
    dash_dur = DUR_W'(DUR_W'(cfg.dot_ms) * DUR_W'(cfg.dash_factor));
    word_dur = DUR_W'(DUR_W'(cfg.dot_ms) * DUR_W'(cfg.word_factor));

    sym       = step_r[3:1];
    sym_dash  = (sym < 3'd5) ? desc_r.dashes[sym] : 1'b0;
    seg_on    = !desc_r.is_space && !step_r[0] && (sym < desc_r.len);
    seg_final = desc_r.is_space || (step_r == {desc_r.len, 1'b0});

    adv  = !out_valid_r || pop;
    emit = busy_r && adv;
    load = !q_empty && (!busy_r || (emit && seg_final));

    desc_nxt = desc_r;
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (load) begin
      desc_nxt = rd_desc;
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (emit) begin
      busy_nxt = !seg_final;
      step_nxt = step_r + 4'd1;
    end

    out_valid_nxt = out_valid_r && !pop;
    led_nxt       = led_r;
    dur_nxt       = dur_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      led_nxt       = seg_on;
      last_nxt      = seg_final;
      if (desc_r.is_space) begin
        dur_nxt = word_dur;
      end else if (seg_on && sym_dash) begin
        dur_nxt = dash_dur;
      end else begin
        dur_nxt = dot_dur;
      end
    end
  end

  assign rd_en           = load;
  assign empty           = !out_valid_r;
  assign out_led_on      = led_r;
  assign out_duration_ms = dur_r;
  assign out_last        = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    led_r  <= led_nxt;
    dur_r  <= dur_nxt;
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/morse_code_keyer.sv -----
// Morse code keyer: one ASCII character in, a run of timed LED segments out.
// Depends on mck_pkg, mck_front, mck_fifo and mck_back.
//
// Input side is a queue: drive in_char_code and raise push; the character
// is taken at an edge where push is high and full is low. Letters of either
// case and digits give their Morse segments, a space gives one dark word gap,
// every other code is taken and dropped without a result.
// Result side is a queue too: while empty is low the oldest segment sits on
// out_led_on / out_duration_ms / out_last; raise pop to take it. out_last
// marks the final segment of a character (the letter gap or the word gap).
// A character's first segment passes the descriptor queue and the back
// end's descriptor register on its way out. The back end issues one segment
// a cycle, 2*n+1 per character of n Morse symbols (3 to 11) and one per
// space, and a queued next character follows with no gap. The front end
// keeps accepting into a QUEUE_DEPTH-entry queue while the back end works.
// If the receiver stalls, the segment holds on the ports, the back end
// waits, and full rises once the descriptor queue fills.
// Reset (rst_n low, synchronous) empties both queues and loads the timing
// registers with 250 ms dot, dash of 5 dots, word gap of 7 dots.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are registered and
// belong to idle periods only; an index past the last register is ignored.
`default_nettype none

module morse_code_keyer
  import mck_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input queue
  input  wire logic              push,
  input  wire logic [CHAR_W-1:0] in_char_code,
  output logic                   full,
  // result queue
  input  wire logic              pop,
  output logic                   empty,
  output logic                   out_led_on,
  output logic [DUR_W-1:0]       out_duration_ms,
  output logic                   out_last,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [DOT_W-1:0]  cfg_wdata
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_full, q_empty;
  logic  q_wr_en, q_rd_en;
  desc_t q_wr_desc, q_rd_desc;

  // Timing registers: keep only the low bits of each register's width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DOT_MS:      cfg_nxt.dot_ms      = cfg_wdata;
        REG_DASH_FACTOR: cfg_nxt.dash_factor = cfg_wdata[FACT_W-1:0];
        REG_WORD_FACTOR: cfg_nxt.word_factor = cfg_wdata[FACT_W-1:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{dot_ms: DOT_MS_RST, dash_factor: DASH_FACTOR_RST,
                 word_factor: WORD_FACTOR_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify and look up the character.
  mck_front u_front (
    .push         (push),
    .in_char_code (in_char_code),
    .full         (full),
    .q_full       (q_full),
    .q_wr_en      (q_wr_en),
    .q_wr_desc    (q_wr_desc)
  );

  // Decouple classification from segment timing.
  mck_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_desc (q_wr_desc),
    .q_full  (q_full),
    .rd_en   (q_rd_en),
    .rd_desc (q_rd_desc),
    .q_empty (q_empty)
  );

  // Walk segments into the output register.
  mck_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .rd_desc         (q_rd_desc),
    .rd_en           (q_rd_en),
    .pop             (pop),
    .empty           (empty),
    .out_led_on      (out_led_on),
    .out_duration_ms (out_duration_ms),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/mck_checker.sv -----
// Port-level checks for the Morse keyer, bound to the top level.
// Depends on mck_pkg and morse_code_keyer_assert.svh.
`default_nettype none
`include "morse_code_keyer_assert.svh"

module mck_checker
  import mck_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             full,
  input wire logic             pop,
  input wire logic             empty,
  input wire logic             out_led_on,
  input wire logic [DUR_W-1:0] out_duration_ms,
  input wire logic             out_last
);

  // A stalled segment stays valid and holds its duration.
  `MCK_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(out_duration_ms)))
  // Reset leaves both queues empty.
  `MCK_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (empty && !full))
  // A lit segment never closes a character.
  `MCK_ASSERT(a_lit_not_last, (!empty && out_led_on) |-> !out_last)
  // Taking a lit segment brings its dark gap on the next cycle.
  `MCK_ASSERT(a_gap_follows, (!empty && pop && out_led_on) |=> (!empty && !out_led_on))

endmodule

bind morse_code_keyer mck_checker u_mck_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .full            (full),
  .pop             (pop),
  .empty           (empty),
  .out_led_on      (out_led_on),
  .out_duration_ms (out_duration_ms),
  .out_last        (out_last)
);

`default_nettype wire

// ----- tb/tb_morse_code_keyer.sv -----
// Self-checking testbench for morse_code_keyer: character items in, LED segments out.
// Depends on mck_pkg for widths, register indexes and ASCII constants; needs only the RTL.
// A local keying predictor builds the expected segments; one checker compares every pop.
`default_nettype none

module tb_morse_code_keyer;
  import mck_pkg::*;

  // Index past the last register: writes to it must be dropped.
  localparam logic [IDX_W-1:0] REG_NONE = 2'd3;
  localparam byte DASH_SYM = 8'h2D;  // '-' in the symbol strings
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PHASE_ITEMS = 18;

  typedef struct packed {
    logic             led_on;
    logic [DUR_W-1:0] duration_ms;
    logic             last;
  } segment_t;

  logic              clk;
  logic              rst_n;
  logic              push;
  logic [CHAR_W-1:0] in_char_code;
  logic              full;
  logic              pop;
  logic              empty;
  logic              out_led_on;
  logic [DUR_W-1:0]  out_duration_ms;
  logic              out_last;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DOT_W-1:0]  cfg_wdata;

  // Keying registers as the predictor sees them.
  logic [DOT_W-1:0]  key_dot_ms;
  logic [FACT_W-1:0] key_dash_factor;
  logic [FACT_W-1:0] key_word_factor;

  segment_t pending_segments[$];
  segment_t seg_want;
  int       mismatch_count;
  int       stall_count;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_off_left;

  morse_code_keyer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .in_char_code   (in_char_code),
    .full           (full),
    .pop            (pop),
    .empty          (empty),
    .out_led_on     (out_led_on),
    .out_duration_ms(out_duration_ms),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Dot/dash pattern per table entry: A-Z first, then 0-9.
  function automatic string symbols_for(input int entry);
    case (entry)
      0: return ".-";     1: return "-...";   2: return "-.-.";   3: return "-..";
      4: return ".";      5: return "..-.";   6: return "--.";    7: return "....";
      8: return "..";     9: return ".---";   10: return "-.-";   11: return ".-..";
      12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
      16: return "--.-";  17: return ".-.";   18: return "...";   19: return "-";
      20: return "..-";   21: return "...-";  22: return ".--";   23: return "-..-";
      24: return "-.--";  25: return "--..";
      26: return "-----"; 27: return ".----"; 28: return "..---"; 29: return "...--";
      30: return "....-"; 31: return "....."; 32: return "-...."; 33: return "--...";
      34: return "---.."; 35: return "----.";
      default: return "";
    endcase
  endfunction

  task automatic expect_segment(input logic on, input logic [DUR_W-1:0] dur,
                                input logic last);
    segment_t seg;
    seg.led_on = on;
    seg.duration_ms = dur;
    seg.last = last;
    pending_segments.push_back(seg);
  endtask

  // Queue the segments one accepted character must produce.
  task automatic predict_segments(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] folded;
    logic [DUR_W-1:0]  dot_len;
    logic [DUR_W-1:0]  dash_len;
    logic [DUR_W-1:0]  word_len;
    int                entry;
    string             code;
    entry = -1;
    dot_len = DUR_W'(key_dot_ms);
    dash_len = DUR_W'(key_dot_ms) * DUR_W'(key_dash_factor);
    word_len = DUR_W'(key_dot_ms) * DUR_W'(key_word_factor);
    folded = (c >= CHAR_LO_A && c <= CHAR_LO_Z) ? c - CASE_OFFSET : c;
    if (folded >= CHAR_UP_A && folded <= CHAR_UP_Z) begin
      entry = int'(folded - CHAR_UP_A);
    end else if (folded >= CHAR_ZERO && folded <= CHAR_NINE) begin
      entry = int'(DIGIT_BASE) + int'(folded - CHAR_ZERO);
    end
    if (c == CHAR_SPACE) begin
      expect_segment(1'b0, word_len, 1'b1);
    end else if (entry >= 0) begin
      code = symbols_for(entry);
      for (int i = 0; i < code.len(); i++) begin
        expect_segment(1'b1, (code[i] == DASH_SYM) ? dash_len : dot_len, 1'b0);
        expect_segment(1'b0, dot_len, 1'b0);
      end
      // letter gap closes the character
      expect_segment(1'b0, dot_len, 1'b1);
    end
  endtask

  // Offer one character; hold it until the block takes it, then predict.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      in_char_code = CHAR_W'($urandom_range(255));
      @(negedge clk);
    end
    push = 1'b1;
    in_char_code = c;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_segments(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop push, drain every expected segment, then let the pipeline empty out
  // in case trailing characters were dropped without a result.
  task automatic settle();
    @(negedge clk);
    push = 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Call only while idle.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DOT_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_index = IDX_W'($urandom_range(3));
    cfg_wdata = DOT_W'($urandom_range(4095));
    case (idx)
      REG_DOT_MS:      key_dot_ms = val;
      REG_DASH_FACTOR: key_dash_factor = val[FACT_W-1:0];
      REG_WORD_FACTOR: key_word_factor = val[FACT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CHAR_W-1:0] random_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return CHAR_UP_A + CHAR_W'($urandom_range(25));
    if (pick < 62) return CHAR_LO_A + CHAR_W'($urandom_range(25));
    if (pick < 78) return CHAR_ZERO + CHAR_W'($urandom_range(9));
    if (pick < 88) return CHAR_SPACE;
    return CHAR_W'($urandom_range(255));
  endfunction

  // Reset timing: letters at both ends, both cases, digits, space, and
  // control or punctuation codes that must be swallowed.
  task automatic test_character_set();
    send_text("AZaz09ETQ /:@[");
    send_char(8'h60);
    send_text("{");
    send_char(8'h0D);
    send_char(8'h0A);
    send_char(8'h00);
    send_char(8'hFF);
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_DOT_MS, 12'd4095);
    write_reg(REG_DASH_FACTOR, 12'd15);
    write_reg(REG_WORD_FACTOR, 12'd15);
    send_text("0 E");
    settle();
    write_reg(REG_DOT_MS, 12'd1);
    write_reg(REG_DASH_FACTOR, 12'd1);
    write_reg(REG_WORD_FACTOR, 12'd1);
    send_text("5 T");
    settle();
  endtask

  // Zero registers, wide write data, and a write to a missing register.
  task automatic test_register_quirks();
    write_reg(REG_DOT_MS, 12'd0);
    send_text("A ");
    settle();
    write_reg(REG_DOT_MS, 12'd100);
    write_reg(REG_DASH_FACTOR, 12'd0);
    write_reg(REG_WORD_FACTOR, 12'd0);
    send_text("N ");
    settle();
    write_reg(REG_DASH_FACTOR, 12'hFA3);
    write_reg(REG_WORD_FACTOR, 12'h5C9);
    send_text("K ");
    settle();
    write_reg(REG_NONE, 12'hABC);
    send_text("D ");
    settle();
  endtask

  // Stall the receiver while the sender keeps pushing long characters, so the
  // descriptor queue fills and full must hold the input off.
  task automatic test_input_backpressure();
    send_idle_pct = 0;
    @(negedge clk);
    hold_off_left = HOLD_OFF_CYCLES;
    send_text("0123456789JQ");
    settle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 36; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // Fresh timing each phase; upper write bits are random on purpose.
      write_reg(REG_DOT_MS, DOT_W'($urandom_range(4095)));
      write_reg(REG_DASH_FACTOR, DOT_W'($urandom_range(4095)));
      write_reg(REG_WORD_FACTOR, DOT_W'($urandom_range(4095)));
      if ($urandom_range(1) == 1) write_reg(REG_NONE, DOT_W'($urandom_range(4095)));
      for (int n = 0; n < RANDOM_PHASE_ITEMS; n++) send_char(random_char());
      settle();
    end
  endtask

  // Receiver: idle at random, or hold off for a counted stretch.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      pop = 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      pop = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each popped segment with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_segments.size() == 0) begin
        $display("%0t: unexpected segment led_on=%0b duration_ms=%0d last=%0b",
                 $time, out_led_on, out_duration_ms, out_last);
        mismatch_count++;
      end else begin
        seg_want = pending_segments.pop_front();
        if (out_led_on !== seg_want.led_on) begin
          $display("%0t: led_on expected %0b actual %0b",
                   $time, seg_want.led_on, out_led_on);
          mismatch_count++;
        end
        if (out_duration_ms !== seg_want.duration_ms) begin
          $display("%0t: duration_ms expected %0d actual %0d",
                   $time, seg_want.duration_ms, out_duration_ms);
          mismatch_count++;
        end
        if (out_last !== seg_want.last) begin
          $display("%0t: last expected %0b actual %0b",
                   $time, seg_want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no item moves on either side for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_count = 0;
    end else begin
      stall_count = stall_count + 1;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_char_code = '0;
    pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatch_count = 0;
    stall_count = 0;
    hold_off_left = 0;
    send_idle_pct = 36;
    recv_idle_pct = 79;
    key_dot_ms = DOT_MS_RST;
    key_dash_factor = DASH_FACTOR_RST;
    key_word_factor = WORD_FACTOR_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_character_set();
    test_register_extremes();
    test_register_quirks();
    test_input_backpressure();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
